/* rtl/servo_command_sequencer_macros.svh */
// Assertion helpers for the servo command sequencer.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SERVO_COMMAND_SEQUENCER_MACROS_SVH
`define SERVO_COMMAND_SEQUENCER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/scs_pkg.sv */
package scs_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_EASE       = 3'd1,
    OP_MOVE       = 3'd2,
    OP_WAIT_SERVO = 3'd3,
    OP_MESSAGE    = 3'd4,
    OP_WAIT       = 3'd5,
    OP_UNBLOCK    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ACT_ACK     = 3'd0,
    ACT_EASE    = 3'd1,
    ACT_WRITE   = 3'd2,
    ACT_MESSAGE = 3'd3,
    ACT_ATTACH  = 3'd4,
    ACT_DETACH  = 3'd5,
    ACT_IDLE    = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    KIND_EASE       = 3'd0,
    KIND_WRITE      = 3'd1,
    KIND_WAIT       = 3'd2,
    KIND_WAIT_SERVO = 3'd3,
    KIND_MESSAGE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_OWN_ID       = 3'd0,
    CFG_HOME_POS     = 3'd1,
    CFG_HOME_SPEED   = 3'd2,
    CFG_HOME_EASING  = 3'd3,
    CFG_GO_HOME      = 3'd4,
    CFG_IDLE_TIMEOUT = 3'd5,
    CFG_SETTLE_WAIT  = 3'd6
  } cfg_reg_e;

  // One queued command, 39 bits.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  angle;
    logic [3:0]  curve;
    logic [15:0] speed;
    logic [7:0]  peer;
  } entry_t;

  // One result item.
  typedef struct packed {
    action_e     action;
    logic [7:0]  angle;
    logic [3:0]  curve;
    logic [15:0] speed;
    logic [7:0]  peer;
    logic        dropped;
  } res_t;

  localparam int unsigned DATA_W    = 40;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RES_SLOTS = 3;

  localparam logic [7:0]  HOME_POS_RST     = 8'd90;
  localparam logic [15:0] HOME_SPEED_RST   = 16'd15;
  localparam logic [3:0]  HOME_EASING_RST  = 4'd0;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] SETTLE_WAIT_RST  = 16'd100;

  function automatic res_t mk_res(action_e act);
    res_t r;
    r        = '0;
    r.action = act;
    return r;
  endfunction

endpackage

/* rtl/servo_command_sequencer.sv */
// After an input transfer (enqueue, unblock, dropped move) the first result is offered in the
// next cycle; a stored move passes S_PUSH2 (second queue write), a tick S_TICK, and a tick
// that pops a command S_TICK and S_DISP (registered queue memory read) before S_OUT.
// One item at a time: input is taken in S_IDLE only, once m_axis has accepted every result.
// Reset (rst_ni low, async): pointers, fill count, time, timers and flags clear, attached set,
// registers to defaults; the queue memory is not cleared and needs no clearing pass.
`include "servo_command_sequencer_macros.svh"

module servo_command_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [scs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [scs_pkg::CFG_W-1:0]           cfg_data_i,
  // command stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // target_angle[7:0], curve_code[11:8], speed_or_delay[27:12], peer_id[35:28],
  // servo_moving[36], zero fill[39:37]
  input  logic [scs_pkg::DATA_W-1:0]          s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]                          s_axis_tuser,
  // result stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // angle_out[7:0], curve_out[11:8], speed_out[27:12], peer_out[35:28],
  // dropped[36], zero fill[39:37]
  output logic [scs_pkg::DATA_W-1:0]          m_axis_tdata,
  // action[2:0]
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for an input transfer
    S_PUSH2,  // second queue write of a move
    S_TICK,   // timed waits, idle timeout, pop decision
    S_DISP,   // queue read data valid: dispatch the popped command
    S_OUT     // hand out the collected results
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  home_pos_q;
  logic [15:0] home_speed_q;
  logic [3:0]  home_easing_q;
  logic        go_home_q;
  logic [15:0] idle_timeout_q;
  logic [15:0] settle_wait_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_pos_q     <= scs_pkg::HOME_POS_RST;
      home_speed_q   <= scs_pkg::HOME_SPEED_RST;
      home_easing_q  <= scs_pkg::HOME_EASING_RST;
      go_home_q      <= 1'b0;
      idle_timeout_q <= scs_pkg::IDLE_TIMEOUT_RST;
      settle_wait_q  <= scs_pkg::SETTLE_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (scs_pkg::cfg_reg_e'(cfg_idx_i))
        // the source id only tags outgoing messages elsewhere; nothing to hold here
        scs_pkg::CFG_OWN_ID:       ;
        scs_pkg::CFG_HOME_POS:     home_pos_q     <= cfg_data_i[7:0];
        scs_pkg::CFG_HOME_SPEED:   home_speed_q   <= cfg_data_i[15:0];
        scs_pkg::CFG_HOME_EASING:  home_easing_q  <= cfg_data_i[3:0];
        scs_pkg::CFG_GO_HOME:      go_home_q      <= cfg_data_i[0];
        scs_pkg::CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i[15:0];
        scs_pkg::CFG_SETTLE_WAIT:  settle_wait_q  <= cfg_data_i[15:0];
        default:                   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpack
  // ---------------------------------------------------------------------------
  scs_pkg::op_e op;
  logic [7:0]   in_angle;
  logic [3:0]   in_curve;
  logic [15:0]  in_speed;
  logic [7:0]   in_peer;
  logic         in_moving;
  logic         accept;

  assign op        = scs_pkg::op_e'(s_axis_tuser);
  assign in_angle  = s_axis_tdata[7:0];
  assign in_curve  = s_axis_tdata[11:8];
  assign in_speed  = s_axis_tdata[27:12];
  assign in_peer   = s_axis_tdata[35:28];
  assign in_moving = s_axis_tdata[36];

  // ---------------------------------------------------------------------------
  // Control and sequencer state
  // ---------------------------------------------------------------------------
  state_e           state_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [PTR_W-1:0] wr_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic [31:0]      time_q;
  logic [31:0]      deadline_q;
  logic [31:0]      idle_since_q;
  logic [7:0]       blocking_q;
  logic             moving_q;
  // status flags
  logic             wait_q;      // timed wait running
  logic             emptied_q;   // queue ran dry, idle timer running
  logic             attached_q;
  logic             home_q;
  logic             going_q;     // easing home in progress
  logic             blocked_q;   // waiting for another servo
  // result list
  logic [1:0]       res_cnt_q;
  logic [1:0]       res_cnt_d;
  logic [1:0]       out_idx_q;
  scs_pkg::res_t    res_q [scs_pkg::RES_SLOTS];
  scs_pkg::res_t    res_d [scs_pkg::RES_SLOTS];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Command queue memory: one write port, one registered read port.
  // The read address is the head pointer; the data is sampled every cycle, so it
  // is valid in S_DISP. Writes only happen in S_IDLE and S_PUSH2, never while a
  // tick is in flight, so a pop never races a write to the same entry.
  // ---------------------------------------------------------------------------
  scs_pkg::entry_t mem_q [QUEUE_DEPTH];
  scs_pkg::entry_t rd_entry_q;
  scs_pkg::entry_t wr_entry;
  logic            wr_en;
  logic            room1;
  logic            room2;

  assign room1 = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign room2 = (fill_q < FILL_W'(QUEUE_DEPTH - 1));

  always_comb begin
    wr_en    = 1'b0;
    wr_entry = '0;
    if (state_q == S_PUSH2) begin
      // settle pause behind the write of a move
      wr_en          = 1'b1;
      wr_entry.kind  = scs_pkg::KIND_WAIT;
      wr_entry.speed = settle_wait_q;
    end else if (accept) begin
      case (op) inside
        scs_pkg::OP_EASE: begin
          wr_en          = room1;
          wr_entry.kind  = scs_pkg::KIND_EASE;
          wr_entry.angle = in_angle;
          wr_entry.curve = in_curve;
          wr_entry.speed = in_speed;
        end
        scs_pkg::OP_MOVE: begin
          // drop the whole move unless both slots are free
          wr_en          = room2;
          wr_entry.kind  = scs_pkg::KIND_WRITE;
          wr_entry.angle = in_angle;
        end
        scs_pkg::OP_WAIT_SERVO: begin
          wr_en         = room1;
          wr_entry.kind = scs_pkg::KIND_WAIT_SERVO;
          wr_entry.peer = in_peer;
        end
        scs_pkg::OP_MESSAGE: begin
          wr_en         = room1;
          wr_entry.kind = scs_pkg::KIND_MESSAGE;
          wr_entry.peer = in_peer;
        end
        scs_pkg::OP_WAIT: begin
          wr_en          = room1;
          wr_entry.kind  = scs_pkg::KIND_WAIT;
          wr_entry.speed = in_speed;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
    rd_entry_q <= mem_q[rd_ptr_q];
  end

  // ---------------------------------------------------------------------------
  // Tick evaluation (S_TICK, time_q already advanced)
  // ---------------------------------------------------------------------------
  logic [31:0] idle_end;
  logic        t_wait, t_going, t_home, t_attached, t_moving;
  logic        t_idle_upd, t_ease, t_detach;
  logic        t_free, t_pop, t_empty;

  assign idle_end = idle_since_q + 32'(idle_timeout_q);

  always_comb begin
    t_wait     = wait_q;
    t_going    = going_q;
    t_home     = home_q;
    t_attached = attached_q;
    t_moving   = moving_q;
    t_idle_upd = 1'b0;
    t_ease     = 1'b0;
    t_detach   = 1'b0;
    if (wait_q) begin
      // end the timed wait once the deadline has passed
      if (time_q > deadline_q) begin
        t_wait = 1'b0;
      end
    end else if (emptied_q && attached_q && !home_q && go_home_q && !going_q) begin
      // idle long enough: ease home; the servo counts as moving for this tick
      if (time_q > idle_end) begin
        t_ease   = 1'b1;
        t_going  = 1'b1;
        t_moving = 1'b1;
      end
    end else if (go_home_q && going_q) begin
      // home reached once motion stops; restart the idle timer
      if (!moving_q) begin
        t_going    = 1'b0;
        t_home     = 1'b1;
        t_idle_upd = 1'b1;
      end
    end else if (emptied_q && attached_q && (home_q || !go_home_q)) begin
      // idle at home (or homing disabled): detach
      if (time_q > idle_end) begin
        t_detach   = 1'b1;
        t_attached = 1'b0;
      end
    end
    t_free  = !t_moving && !blocked_q && !t_wait;
    t_pop   = t_free && (fill_q != '0);
    t_empty = t_free && (fill_q == '0) && !emptied_q;
  end

  // ---------------------------------------------------------------------------
  // Dispatch of the popped command (S_DISP)
  // ---------------------------------------------------------------------------
  logic          d_att;
  logic          d_emit;
  scs_pkg::res_t d_res;
  logic [1:0]    d_slot;
  logic [1:0]    d_total;

  always_comb begin
    d_att  = !attached_q;
    d_emit = 1'b0;
    d_res  = scs_pkg::mk_res(scs_pkg::ACT_IDLE);
    case (rd_entry_q.kind)
      scs_pkg::KIND_EASE: begin
        d_emit      = 1'b1;
        d_res       = scs_pkg::mk_res(scs_pkg::ACT_EASE);
        d_res.angle = rd_entry_q.angle;
        d_res.curve = rd_entry_q.curve;
        d_res.speed = rd_entry_q.speed;
      end
      scs_pkg::KIND_WRITE: begin
        d_emit      = 1'b1;
        d_res       = scs_pkg::mk_res(scs_pkg::ACT_WRITE);
        d_res.angle = rd_entry_q.angle;
      end
      scs_pkg::KIND_MESSAGE: begin
        d_emit     = 1'b1;
        d_res      = scs_pkg::mk_res(scs_pkg::ACT_MESSAGE);
        d_res.peer = rd_entry_q.peer;
      end
      default: ;
    endcase
    d_slot  = res_cnt_q + 2'(d_att);
    d_total = d_slot + 2'(d_emit);
  end

  // ---------------------------------------------------------------------------
  // Result list: collect up to three results per item, then hand them out
  // ---------------------------------------------------------------------------
  always_comb begin
    res_d     = res_q;
    res_cnt_d = res_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_cnt_d = 2'd1;
          res_d[0]  = scs_pkg::mk_res(scs_pkg::ACT_IDLE);
          case (op) inside
            scs_pkg::OP_EASE, scs_pkg::OP_MOVE, scs_pkg::OP_WAIT_SERVO,
            scs_pkg::OP_MESSAGE, scs_pkg::OP_WAIT: begin
              res_d[0]         = scs_pkg::mk_res(scs_pkg::ACT_ACK);
              res_d[0].dropped = !wr_en;
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        res_cnt_d = 2'd0;
        if (t_ease) begin
          res_d[0]       = scs_pkg::mk_res(scs_pkg::ACT_EASE);
          res_d[0].angle = home_pos_q;
          res_d[0].curve = home_easing_q;
          res_d[0].speed = home_speed_q;
          res_cnt_d      = 2'd1;
        end else if (t_detach) begin
          res_d[0]  = scs_pkg::mk_res(scs_pkg::ACT_DETACH);
          res_cnt_d = 2'd1;
        end else if (!t_pop) begin
          res_d[0]  = scs_pkg::mk_res(scs_pkg::ACT_IDLE);
          res_cnt_d = 2'd1;
        end
      end
      S_DISP: begin
        if (d_att) begin
          res_d[res_cnt_q] = scs_pkg::mk_res(scs_pkg::ACT_ATTACH);
        end
        if (d_emit) begin
          res_d[d_slot] = d_res;
        end
        res_cnt_d = d_total;
        if (d_total == 2'd0) begin
          res_d[0]  = scs_pkg::mk_res(scs_pkg::ACT_IDLE);
          res_cnt_d = 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_last;

  assign out_last = (out_idx_q == res_cnt_q - 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      fill_q       <= '0;
      time_q       <= '0;
      deadline_q   <= '0;
      idle_since_q <= '0;
      blocking_q   <= '0;
      moving_q     <= 1'b0;
      wait_q       <= 1'b0;
      emptied_q    <= 1'b0;
      attached_q   <= 1'b1;
      home_q       <= 1'b0;
      going_q      <= 1'b0;
      blocked_q    <= 1'b0;
      res_cnt_q    <= '0;
      out_idx_q    <= '0;
    end else begin
      res_cnt_q <= res_cnt_d;
      if (wr_en) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
        fill_q   <= fill_q + 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          out_idx_q <= '0;
          if (accept) begin
            case (op)
              scs_pkg::OP_TICK: begin
                time_q   <= time_q + 32'd1;
                moving_q <= in_moving;
                state_q  <= S_TICK;
              end
              scs_pkg::OP_MOVE: begin
                state_q <= wr_en ? S_PUSH2 : S_OUT;
              end
              scs_pkg::OP_UNBLOCK: begin
                // lift the block only for the servo we wait on
                if (blocked_q && (in_peer == blocking_q)) begin
                  blocked_q <= 1'b0;
                end
                state_q <= S_OUT;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_PUSH2: begin
          state_q <= S_OUT;
        end
        S_TICK: begin
          wait_q     <= t_wait;
          going_q    <= t_going;
          home_q     <= t_home;
          attached_q <= t_attached;
          if (t_idle_upd || t_empty) begin
            idle_since_q <= time_q;
          end
          if (t_empty) begin
            emptied_q <= 1'b1;
          end
          state_q <= t_pop ? S_DISP : S_OUT;
        end
        S_DISP: begin
          // pop the head; re-attach before any motion
          rd_ptr_q   <= ptr_inc(rd_ptr_q);
          fill_q     <= fill_q - 1'b1;
          emptied_q  <= 1'b0;
          attached_q <= 1'b1;
          case (rd_entry_q.kind) inside
            scs_pkg::KIND_EASE, scs_pkg::KIND_WRITE: begin
              home_q <= 1'b0;
            end
            scs_pkg::KIND_WAIT_SERVO: begin
              blocking_q <= rd_entry_q.peer;
              blocked_q  <= 1'b1;
            end
            scs_pkg::KIND_WAIT: begin
              wait_q     <= 1'b1;
              deadline_q <= time_q + 32'(rd_entry_q.speed);
            end
            default: ;
          endcase
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (out_last) begin
              state_q <= S_IDLE;
            end else begin
              out_idx_q <= out_idx_q + 2'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output
  // ---------------------------------------------------------------------------
  scs_pkg::res_t out_res;

  assign out_res       = res_q[out_idx_q];
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = out_res.action;
  assign m_axis_tdata  = {3'b000, out_res.dropped, out_res.peer, out_res.speed,
                          out_res.curve, out_res.angle};
  assign m_axis_tlast  = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic move_store;

  assign move_store = accept && wr_en && (op == scs_pkg::OP_MOVE);

  `SCS_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")
  `SCS_ASSERT_IMP(a_pop_nonempty, state_q == S_DISP, fill_q != '0, "pop from empty queue")
  `SCS_ASSERT_IMP(a_out_index, state_q == S_OUT, out_idx_q < res_cnt_q, "bad result index")
  `SCS_ASSERT_NXT(a_move_pair, move_store, state_q == S_PUSH2 && wr_en, "move lost its wait")

endmodule

/* dv/servo_command_sequencer_tb.sv */
`timescale 1ns / 1ps

module servo_command_sequencer_tb;

  localparam int unsigned DEPTH = 16;
  // Operation code outside the defined set; the block must ignore it.
  localparam logic [2:0] OP_UNDEFINED = 3'd7;

  // Tracks the queue, timers and flags of the sequencer and holds the actions
  // it must produce, oldest first.
  class servo_action_tracker;
    typedef struct {
      scs_pkg::res_t res;
      bit            last;
    } expected_action_t;

    expected_action_t pending[$];
    scs_pkg::res_t    step_out[$];
    int unsigned      errors;

    scs_pkg::entry_t  mem[DEPTH];
    int unsigned      rd, wr, fill;
    bit [31:0]        now_ms, wait_end, idle_from;
    bit [7:0]         blocker;
    bit               wait_time, emptied, attached, at_home, going_home, blocked;

    bit [7:0]         own_id, home_pos;
    bit [15:0]        home_spd, idle_ms, settle_ms;
    bit [3:0]         home_curve;
    bit               go_home;

    function new();
      rd = 0; wr = 0; fill = 0;
      now_ms = 0; wait_end = 0; idle_from = 0;
      blocker = 0;
      wait_time = 0; emptied = 0; attached = 1; at_home = 0; going_home = 0; blocked = 0;
      own_id = 0; home_pos = scs_pkg::HOME_POS_RST; home_spd = scs_pkg::HOME_SPEED_RST;
      home_curve = scs_pkg::HOME_EASING_RST; go_home = 0;
      idle_ms = scs_pkg::IDLE_TIMEOUT_RST; settle_ms = scs_pkg::SETTLE_WAIT_RST;
      errors = 0;
    endfunction

    function void set_reg(scs_pkg::cfg_reg_e idx, logic [15:0] v);
      case (idx)
        scs_pkg::CFG_OWN_ID:       own_id = v[7:0];
        scs_pkg::CFG_HOME_POS:     home_pos = v[7:0];
        scs_pkg::CFG_HOME_SPEED:   home_spd = v;
        scs_pkg::CFG_HOME_EASING:  home_curve = v[3:0];
        scs_pkg::CFG_GO_HOME:      go_home = v[0];
        scs_pkg::CFG_IDLE_TIMEOUT: idle_ms = v;
        scs_pkg::CFG_SETTLE_WAIT:  settle_ms = v;
        default: ;
      endcase
    endfunction

    function void add_action(scs_pkg::action_e act, logic [7:0] a, logic [3:0] c,
                             logic [15:0] s, logic [7:0] p, logic d);
      scs_pkg::res_t r;
      if (step_out.size() < scs_pkg::RES_SLOTS) begin
        r = '0;
        r.action = act; r.angle = a; r.curve = c; r.speed = s; r.peer = p; r.dropped = d;
        step_out.push_back(r);
      end
    endfunction

    function void enqueue(scs_pkg::kind_e k, logic [7:0] a, logic [3:0] c, logic [15:0] s,
                          logic [7:0] p);
      scs_pkg::entry_t e;
      e.kind = k; e.angle = a; e.curve = c; e.speed = s; e.peer = p;
      mem[wr] = e;
      wr = (wr + 1) % DEPTH;
      fill++;
    endfunction

    // One millisecond step: timed wait, idle handling, then dispatch.
    function void advance_clock(bit moving);
      bit              mv;
      bit [31:0]       limit;
      scs_pkg::entry_t e;
      mv = moving;
      now_ms++;
      limit = idle_from + {16'd0, idle_ms};
      if (wait_time) begin
        if (now_ms > wait_end) wait_time = 0;
      end else if (emptied && attached && !at_home && go_home && !going_home) begin
        if (now_ms > limit) begin
          add_action(scs_pkg::ACT_EASE, home_pos, home_curve, home_spd, 8'd0, 1'b0);
          going_home = 1;
          mv = 1;
        end
      end else if (go_home && going_home) begin
        if (!mv) begin
          going_home = 0;
          at_home = 1;
          idle_from = now_ms;
        end
      end else if (emptied && attached && (at_home || !go_home)) begin
        if (now_ms > limit) begin
          add_action(scs_pkg::ACT_DETACH, 8'd0, 4'd0, 16'd0, 8'd0, 1'b0);
          attached = 0;
        end
      end

      if (!mv && !blocked && !wait_time) begin
        if (fill != 0) begin
          e = mem[rd];
          rd = (rd + 1) % DEPTH;
          fill--;
          emptied = 0;
          if (!attached) begin
            add_action(scs_pkg::ACT_ATTACH, 8'd0, 4'd0, 16'd0, 8'd0, 1'b0);
            attached = 1;
          end
          case (e.kind)
            scs_pkg::KIND_EASE: begin
              add_action(scs_pkg::ACT_EASE, e.angle, e.curve, e.speed, 8'd0, 1'b0);
              at_home = 0;
            end
            scs_pkg::KIND_WRITE: begin
              add_action(scs_pkg::ACT_WRITE, e.angle, 4'd0, 16'd0, 8'd0, 1'b0);
              at_home = 0;
            end
            scs_pkg::KIND_WAIT_SERVO: begin
              blocker = e.peer;
              blocked = 1;
            end
            scs_pkg::KIND_MESSAGE:
              add_action(scs_pkg::ACT_MESSAGE, 8'd0, 4'd0, 16'd0, e.peer, 1'b0);
            scs_pkg::KIND_WAIT: begin
              wait_time = 1;
              wait_end = now_ms + {16'd0, e.speed};
            end
            default: ;
          endcase
        end else if (!emptied) begin
          emptied = 1;
          idle_from = now_ms;
        end
      end
    endfunction

    function void note_command(logic [2:0] op, logic [7:0] angle, logic [3:0] curve,
                               logic [15:0] spd, logic [7:0] peer, bit moving);
      int unsigned room;
      expected_action_t x;
      room = DEPTH - fill;
      step_out.delete();
      case (op) inside
        scs_pkg::OP_TICK: advance_clock(moving);
        scs_pkg::OP_EASE, scs_pkg::OP_WAIT_SERVO, scs_pkg::OP_MESSAGE, scs_pkg::OP_WAIT: begin
          if (room >= 1) begin
            case (op)
              scs_pkg::OP_EASE:
                enqueue(scs_pkg::KIND_EASE, angle, curve, spd, 8'd0);
              scs_pkg::OP_WAIT_SERVO:
                enqueue(scs_pkg::KIND_WAIT_SERVO, 8'd0, 4'd0, 16'd0, peer);
              scs_pkg::OP_MESSAGE:
                enqueue(scs_pkg::KIND_MESSAGE, 8'd0, 4'd0, 16'd0, peer);
              default:
                enqueue(scs_pkg::KIND_WAIT, 8'd0, 4'd0, spd, 8'd0);
            endcase
            add_action(scs_pkg::ACT_ACK, 8'd0, 4'd0, 16'd0, 8'd0, 1'b0);
          end else begin
            add_action(scs_pkg::ACT_ACK, 8'd0, 4'd0, 16'd0, 8'd0, 1'b1);
          end
        end
        scs_pkg::OP_MOVE: begin
          // a move takes two slots or none
          if (room >= 2) begin
            enqueue(scs_pkg::KIND_WRITE, angle, 4'd0, 16'd0, 8'd0);
            enqueue(scs_pkg::KIND_WAIT, 8'd0, 4'd0, settle_ms, 8'd0);
            add_action(scs_pkg::ACT_ACK, 8'd0, 4'd0, 16'd0, 8'd0, 1'b0);
          end else begin
            add_action(scs_pkg::ACT_ACK, 8'd0, 4'd0, 16'd0, 8'd0, 1'b1);
          end
        end
        scs_pkg::OP_UNBLOCK: if (blocked && peer == blocker) blocked = 0;
        default: ;
      endcase
      if (step_out.size() == 0)
        add_action(scs_pkg::ACT_IDLE, 8'd0, 4'd0, 16'd0, 8'd0, 1'b0);
      foreach (step_out[i]) begin
        x.res = step_out[i];
        x.last = (i == step_out.size() - 1);
        pending.push_back(x);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_action(logic [2:0] act, logic [scs_pkg::DATA_W-1:0] data, logic last);
      expected_action_t x;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got action %0d data %0h",
                 $time, act, data);
        return;
      end
      x = pending.pop_front();
      compare_field("action", 32'(x.res.action), 32'(act));
      compare_field("angle", 32'(x.res.angle), 32'(data[7:0]));
      compare_field("curve", 32'(x.res.curve), 32'(data[11:8]));
      compare_field("speed", 32'(x.res.speed), 32'(data[27:12]));
      compare_field("peer", 32'(x.res.peer), 32'(data[35:28]));
      compare_field("dropped", 32'(x.res.dropped), 32'(data[36]));
      compare_field("zero fill", 32'd0, 32'(data[39:37]));
      compare_field("last", 32'(x.last), 32'(last));
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [scs_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [scs_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // target_angle[7:0], curve_code[11:8], speed_or_delay[27:12], peer_id[35:28],
  // servo_moving[36], zero fill[39:37]
  logic [scs_pkg::DATA_W-1:0]    s_axis_tdata = '0;
  // operation[2:0]
  logic [2:0]                    s_axis_tuser = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // angle_out[7:0], curve_out[11:8], speed_out[27:12], peer_out[35:28],
  // dropped[36], zero fill[39:37]
  logic [scs_pkg::DATA_W-1:0]    m_axis_tdata;
  // action[2:0]
  logic [2:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  servo_action_tracker tracker;

  // sender burst state
  int unsigned burst_left = 0;

  // receiver stall state
  int unsigned ready_mode = 0;
  int unsigned ready_run = 0;
  bit [7:0]    ready_bits = 8'hff;

  servo_command_sequencer #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver backpressure: when each random run ends, pick a new mode. Mode 0
  // keeps tready high for the whole run, mode 1 follows a rotating random
  // byte, mode 2 accepts one cycle in four.
  always @(negedge clk_i) begin
    if (ready_run == 0) begin
      ready_run = $urandom_range(8, 40);
      ready_mode = $urandom_range(0, 2);
      ready_bits = 8'($urandom);
      if (ready_bits == 0) ready_bits = 8'h21;
    end
    ready_run--;
    ready_bits = {ready_bits[6:0], ready_bits[7]};
    case (ready_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ready_bits[0];
      default: m_axis_tready <= (ready_run % 4 == 0);
    endcase
  end

  // Check every result transfer against the oldest expected action.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_action(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // Write one register while the block is idle; hold the enable for one edge.
  task automatic write_reg(scs_pkg::cfg_reg_e idx, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    tracker.set_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Offer one command; insert a random gap at the start of each burst and
  // hold tvalid high inside a burst. Enter and leave at a falling edge.
  task automatic send_command(logic [2:0] op, logic [7:0] angle, logic [3:0] curve,
                              logic [15:0] spd, logic [7:0] peer, bit moving);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, moving, peer, spd, curve, angle};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_command(op, angle, curve, spd, peer, moving);
    @(negedge clk_i);
  endtask

  task automatic tick(bit moving);
    send_command(scs_pkg::OP_TICK, 8'($urandom), 4'($urandom), 16'($urandom), 8'($urandom),
                 moving);
  endtask

  // Random command with most content random; waits are kept short so the
  // queue keeps flowing, and unblocks often name the peer being waited on.
  task automatic send_random(int unsigned tick_pct, int unsigned enq_pct);
    int unsigned pick;
    logic [2:0]  op;
    logic [7:0]  angle, peer;
    logic [3:0]  curve;
    logic [15:0] spd;
    bit          moving;
    pick = $urandom_range(0, 99);
    angle = 8'($urandom);
    curve = 4'($urandom);
    spd = 16'($urandom);
    peer = 8'($urandom);
    moving = ($urandom_range(0, 4) == 0);
    if (pick < tick_pct) begin
      op = scs_pkg::OP_TICK;
    end else if (pick < tick_pct + enq_pct) begin
      case ($urandom_range(0, 8))
        0, 1:    op = scs_pkg::OP_EASE;
        2, 3, 4: op = scs_pkg::OP_MOVE;
        5:       op = scs_pkg::OP_WAIT_SERVO;
        6:       op = scs_pkg::OP_MESSAGE;
        default: op = scs_pkg::OP_WAIT;
      endcase
    end else if (pick < 98) begin
      op = scs_pkg::OP_UNBLOCK;
    end else begin
      op = OP_UNDEFINED;
    end
    if (op == scs_pkg::OP_WAIT)
      spd = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 60))
                                         : 16'($urandom_range(0, 6));
    if (op == scs_pkg::OP_WAIT_SERVO)
      peer = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    if (op == scs_pkg::OP_UNBLOCK && tracker.blocked && $urandom_range(0, 2) != 0)
      peer = tracker.blocker;
    send_command(op, angle, curve, spd, peer, moving);
  endtask

  // Drop tvalid and wait until every expected action has come back, then
  // let the block settle before the next register write.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned count, int unsigned tick_pct, int unsigned enq_pct);
    repeat (count) send_random(tick_pct, enq_pct);
    drain_block();
  endtask

  initial begin
    tracker = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short timeouts so the idle path shows up quickly; home target stays
    // at its reset values.
    write_reg(scs_pkg::CFG_GO_HOME, 16'd1);
    write_reg(scs_pkg::CFG_IDLE_TIMEOUT, 16'd2);
    write_reg(scs_pkg::CFG_SETTLE_WAIT, 16'd1);

    // Empty queue: mark idle, ignore an undefined op and a stray unblock.
    tick(1'b0);
    send_command(OP_UNDEFINED, 8'hff, 4'hf, 16'hffff, 8'hff, 1'b1);
    send_command(scs_pkg::OP_UNBLOCK, 8'h00, 4'h0, 16'h0000, 8'h00, 1'b0);
    // Run into the timeout: ease home, stay moving once, arrive, then detach.
    tick(1'b0); tick(1'b0); tick(1'b0);
    tick(1'b1);
    tick(1'b0); tick(1'b0); tick(1'b0); tick(1'b0);
    // Queue every kind of command with extreme fields.
    send_command(scs_pkg::OP_EASE, 8'hff, 4'hf, 16'hffff, 8'h00, 1'b0);
    send_command(scs_pkg::OP_MOVE, 8'h00, 4'h0, 16'h0000, 8'hff, 1'b1);
    send_command(scs_pkg::OP_WAIT_SERVO, 8'h00, 4'h0, 16'h0000, 8'h00, 1'b0);
    send_command(scs_pkg::OP_MESSAGE, 8'h00, 4'h0, 16'h0000, 8'hff, 1'b0);
    send_command(scs_pkg::OP_WAIT, 8'h00, 4'h0, 16'h0000, 8'h00, 1'b0);
    // Re-attach and dispatch; a moving tick holds dispatch.
    tick(1'b0);
    tick(1'b1);
    tick(1'b0); tick(1'b0); tick(1'b0); tick(1'b0);
    // Block on peer 0: a wrong peer leaves it, peer 0 lifts it.
    send_command(scs_pkg::OP_UNBLOCK, 8'h00, 4'h0, 16'h0000, 8'h01, 1'b0);
    tick(1'b0);
    send_command(scs_pkg::OP_UNBLOCK, 8'h00, 4'h0, 16'h0000, 8'h00, 1'b0);
    tick(1'b0); tick(1'b0); tick(1'b0);
    drain_block();

    // Top extremes of the home settings, zero timeout and zero settle time.
    write_reg(scs_pkg::CFG_OWN_ID, 16'd255);
    write_reg(scs_pkg::CFG_HOME_POS, 16'd255);
    write_reg(scs_pkg::CFG_HOME_SPEED, 16'hffff);
    write_reg(scs_pkg::CFG_HOME_EASING, 16'd15);
    write_reg(scs_pkg::CFG_IDLE_TIMEOUT, 16'd0);
    write_reg(scs_pkg::CFG_SETTLE_WAIT, 16'd0);
    run_phase(110, 55, 35);

    // Bottom extremes; enqueue-heavy so the queue fills and drops.
    write_reg(scs_pkg::CFG_OWN_ID, 16'h005a);
    write_reg(scs_pkg::CFG_HOME_POS, 16'd0);
    write_reg(scs_pkg::CFG_HOME_SPEED, 16'd0);
    write_reg(scs_pkg::CFG_HOME_EASING, 16'd0);
    write_reg(scs_pkg::CFG_IDLE_TIMEOUT, 16'd7);
    write_reg(scs_pkg::CFG_SETTLE_WAIT, 16'd3);
    run_phase(110, 25, 65);

    // No return home: idle timeout detaches directly.
    write_reg(scs_pkg::CFG_GO_HOME, 16'd0);
    write_reg(scs_pkg::CFG_HOME_POS, 16'd90);
    write_reg(scs_pkg::CFG_IDLE_TIMEOUT, 16'd4);
    write_reg(scs_pkg::CFG_SETTLE_WAIT, 16'd1);
    run_phase(100, 40, 50);

    // Longest idle timeout: the servo never gives up while this phase runs.
    write_reg(scs_pkg::CFG_GO_HOME, 16'd1);
    write_reg(scs_pkg::CFG_IDLE_TIMEOUT, 16'hffff);
    write_reg(scs_pkg::CFG_SETTLE_WAIT, 16'd2);
    run_phase(100, 40, 50);

    // Longest settle and wait times; nothing can follow them, so run last.
    write_reg(scs_pkg::CFG_OWN_ID, 16'd0);
    write_reg(scs_pkg::CFG_SETTLE_WAIT, 16'hffff);
    if (tracker.blocked)
      send_command(scs_pkg::OP_UNBLOCK, 8'h00, 4'h0, 16'h0000, tracker.blocker, 1'b0);
    send_command(scs_pkg::OP_MOVE, 8'h80, 4'h5, 16'h1234, 8'h42, 1'b0);
    send_command(scs_pkg::OP_WAIT, 8'h00, 4'h0, 16'hffff, 8'h00, 1'b0);
    repeat (6) tick(1'b0);
    drain_block();

    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
